[hw/rtl/tlbl_pkg.sv]
// ----------------------------------------------------------------------------
// tlbl_pkg
// shared constants, types and state codes of the breadth-first leaf lister
// ----------------------------------------------------------------------------
package tlbl_pkg;

   localparam int MAX_NODES = 16;
   localparam int NODE_W    = 4;
   localparam int COUNT_W   = 5;

   typedef struct packed {
      logic              present;
      logic [NODE_W-1:0] index;
   } child_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MARK,
      ST_ROOT,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load_en;
      logic mark_clear;
      logic mark_step;
      logic walk_start;
      logic walk_step;
      logic flush_emit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic walk_done;
      logic step_stall;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/tlbl_req_if.sv]
// ----------------------------------------------------------------------------
// tlbl_req_if
// node transaction channel: one tree node per transaction
// ----------------------------------------------------------------------------
interface tlbl_req_if;
   logic                      valid;
   logic                      ready;
   logic [tlbl_pkg::NODE_W-1:0] left_index;
   logic                      left_valid;
   logic [tlbl_pkg::NODE_W-1:0] right_index;
   logic                      right_valid;
   logic                      last_node;

   modport source (output valid, left_index, left_valid, right_index, right_valid,
                   last_node, input ready);
   modport sink   (input valid, left_index, left_valid, right_index, right_valid,
                   last_node, output ready);
endinterface

[hw/rtl/tlbl_rsp_if.sv]
// ----------------------------------------------------------------------------
// tlbl_rsp_if
// leaf transaction channel: one leaf index per transaction
// ----------------------------------------------------------------------------
interface tlbl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tlbl_pkg::NODE_W-1:0] leaf_index;
   logic                      last_leaf;

   modport source (output valid, leaf_index, last_leaf, input ready);
   modport sink   (input valid, leaf_index, last_leaf, output ready);
endinterface

[hw/rtl/tlbl_ctrl.sv]
// ----------------------------------------------------------------------------
// tlbl_ctrl
// sequencer: load, child marking, root pick, breadth-first walk, final flush
// ----------------------------------------------------------------------------
module tlbl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  tlbl_pkg::status_type status,
   output tlbl_pkg::cmd_type    cmd
);

   tlbl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlbl_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tlbl_pkg::ST_LOAD: begin
            req_ready   = 1'b1;
            cmd.load_en = req_valid;
            if (req_valid && req_last) begin
               cmd.mark_clear = 1'b1;
               state_in       = tlbl_pkg::ST_MARK;
            end
         end
         tlbl_pkg::ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (status.scan_done) begin
               state_in = tlbl_pkg::ST_ROOT;
            end
         end
         tlbl_pkg::ST_ROOT: begin
            cmd.walk_start = 1'b1;
            state_in       = tlbl_pkg::ST_WALK;
         end
         tlbl_pkg::ST_WALK: begin
            if (status.walk_done) begin
               state_in = tlbl_pkg::ST_FLUSH;
            end else begin
               cmd.walk_step = !status.step_stall;
            end
         end
         tlbl_pkg::ST_FLUSH: begin
            // final leaf goes out flagged once the output register is free
            if (!status.pend_valid || status.out_free) begin
               cmd.flush_emit = 1'b1;
               state_in       = tlbl_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = tlbl_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

[hw/rtl/tlbl_datapath.sv]
// ----------------------------------------------------------------------------
// tlbl_datapath
// child tables, child marks, walk fifo, pending leaf and output register
// ----------------------------------------------------------------------------
module tlbl_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  tlbl_pkg::cmd_type           cmd,
   output tlbl_pkg::status_type        status,
   input  logic [tlbl_pkg::NODE_W-1:0] in_left_index,
   input  logic                        in_left_valid,
   input  logic [tlbl_pkg::NODE_W-1:0] in_right_index,
   input  logic                        in_right_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [tlbl_pkg::NODE_W-1:0] rsp_leaf_index,
   output logic                        rsp_last_leaf
);

   localparam int NW = tlbl_pkg::NODE_W;
   localparam int CW = tlbl_pkg::COUNT_W;
   localparam int MN = tlbl_pkg::MAX_NODES;

   tlbl_pkg::child_type left_ff  [MN];
   tlbl_pkg::child_type right_ff [MN];
   logic [NW-1:0]       slot_ff  [MN];

   logic [CW-1:0] count_ff, count_in;
   logic [MN-1:0] mark_ff, mark_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [NW-1:0] head_ff, head_in;
   logic [NW-1:0] tail_ff, tail_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] pops_ff, pops_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [NW-1:0] pend_index_ff;
   logic          out_valid_ff, out_valid_in;
   logic [NW-1:0] out_index_ff;
   logic          out_last_ff;

   tlbl_pkg::child_type scan_l, scan_r, node_l, node_r;
   logic          scan_lc, scan_rc, node_lc, node_rc;
   logic [NW-1:0] node;
   logic [NW-1:0] root;
   logic          leaf, out_free, push_l, push_r;
   logic          load_out_walk, load_out_flush;

   function automatic logic child_ok(tlbl_pkg::child_type e, logic [CW-1:0] n);
      child_ok = e.present && ({1'b0, e.index} < n);
   endfunction

   // node under scan while marking children
   assign scan_l  = left_ff[scan_ff[NW-1:0]];
   assign scan_r  = right_ff[scan_ff[NW-1:0]];
   assign scan_lc = child_ok(scan_l, count_ff);
   assign scan_rc = child_ok(scan_r, count_ff);

   // node at the fifo head during the walk
   assign node    = slot_ff[head_ff];
   assign node_l  = left_ff[node];
   assign node_r  = right_ff[node];
   assign node_lc = child_ok(node_l, count_ff);
   assign node_rc = child_ok(node_r, count_ff);
   assign leaf    = !node_lc && !node_rc;

   // after the pop one slot is free, so the first push always fits
   assign push_l = node_lc;
   assign push_r = node_rc && (!node_lc || (fill_ff != CW'(MN)));

   // lowest unmarked node below the count, node 0 when every node is marked
   always_comb begin
      root = '0;
      for (int k = MN - 1; k >= 0; k--) begin
         if ((CW'(k) < count_ff) && !mark_ff[k]) begin
            root = NW'(k);
         end
      end
   end

   assign out_free       = !out_valid_ff || rsp_ready;
   assign load_out_walk  = cmd.walk_step && leaf && pend_valid_ff;
   assign load_out_flush = cmd.flush_emit && pend_valid_ff;

   always_comb begin
      status.scan_done  = (scan_ff + CW'(1)) >= count_ff;
      status.walk_done  = (fill_ff == '0) || (pops_ff >= count_ff);
      status.step_stall = leaf && pend_valid_ff && !out_free;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   always_comb begin
      count_in      = count_ff;
      mark_in       = mark_ff;
      scan_in       = scan_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      pops_in       = pops_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      // nodes beyond the table depth are dropped
      if (cmd.load_en && (count_ff < CW'(MN))) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.mark_clear) begin
         mark_in = '0;
         scan_in = '0;
      end
      if (cmd.mark_step) begin
         if (scan_lc) mark_in[scan_l.index] = 1'b1;
         if (scan_rc) mark_in[scan_r.index] = 1'b1;
         scan_in = scan_ff + CW'(1);
      end
      if (cmd.walk_start) begin
         head_in = '0;
         tail_in = NW'(1);
         fill_in = CW'(1);
         pops_in = '0;
      end
      if (cmd.walk_step) begin
         head_in = head_ff + NW'(1);
         pops_in = pops_ff + CW'(1);
         tail_in = tail_ff + NW'(push_l) + NW'(push_r);
         fill_in = fill_ff - CW'(1) + CW'(push_l) + CW'(push_r);
         if (leaf) pend_valid_in = 1'b1;
      end
      if (cmd.flush_emit) begin
         pend_valid_in = 1'b0;
         count_in      = '0;
      end
      if (load_out_walk || load_out_flush) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         mark_ff       <= '0;
         scan_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         pops_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         mark_ff       <= mark_in;
         scan_ff       <= scan_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         pops_ff       <= pops_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en && (count_ff < CW'(MN))) begin
         left_ff[count_ff[NW-1:0]]  <= '{present: in_left_valid,  index: in_left_index};
         right_ff[count_ff[NW-1:0]] <= '{present: in_right_valid, index: in_right_index};
      end
      if (cmd.walk_start) begin
         slot_ff[0] <= root;
      end
      if (cmd.walk_step) begin
         if (push_l) slot_ff[tail_ff] <= node_l.index;
         if (push_r) slot_ff[tail_ff + NW'(push_l)] <= node_r.index;
         if (leaf) pend_index_ff <= node;
      end
      if (load_out_walk) begin
         out_index_ff <= pend_index_ff;
         out_last_ff  <= 1'b0;
      end else if (load_out_flush) begin
         out_index_ff <= pend_index_ff;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_leaf_index = out_index_ff;
   assign rsp_last_leaf  = out_last_ff;

endmodule

[hw/rtl/tree_leaf_bfs_lister.sv]
// ----------------------------------------------------------------------------
// tree_leaf_bfs_lister
// lists the leaves of a binary tree in breadth-first order
// ----------------------------------------------------------------------------
// Nodes arrive one per cycle, numbered from 0 in arrival order, up to 16 kept.
// The transaction marked last_node starts the walk and input is held off until
// it is done: the children are marked (one stored node per cycle), the root is
// picked, the walk fifo is popped one node per cycle, at most once per stored
// node, while rsp back-pressure can stall it once two leaves are waiting, the
// walk is seen to finish and the final leaf is released once the output
// register is free. The single pop per cycle of the walk fifo sets the walk
// rate while the walk does not stall. Leaves leave through an output register,
// the last one flagged with last_leaf; a tree without a leaf gives no
// transaction.
module tree_leaf_bfs_lister (
   input  logic       clock,
   input  logic       reset,
   tlbl_req_if.sink   req_if,
   tlbl_rsp_if.source rsp_if
);

   tlbl_pkg::cmd_type    cmd;
   tlbl_pkg::status_type status;

   tlbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_node),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlbl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_left_index  (req_if.left_index),
      .in_left_valid  (req_if.left_valid),
      .in_right_index (req_if.right_index),
      .in_right_valid (req_if.right_valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_leaf_index (rsp_if.leaf_index),
      .rsp_last_leaf  (rsp_if.last_leaf)
   );

endmodule

[hw/rtl/tlbl_checker.sv]
// ----------------------------------------------------------------------------
// tlbl_checker
// port-level checks of the leaf lister, bound to the top level
// ----------------------------------------------------------------------------
module tlbl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last_node,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tlbl_pkg::NODE_W-1:0] rsp_leaf_index,
   input logic                        rsp_last_leaf
);

   // a stalled leaf transaction holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_leaf_index)
                                   && $stable(rsp_last_leaf))
      else $error("leaf transaction changed while stalled");

   // the last node starts the walk, so input closes straight after it
   walk_closes_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_node |=> !req_ready)
      else $error("input still open after last node");

   // while loading, input stays open
   load_stays_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_node |=> req_ready)
      else $error("input closed in the middle of a tree");

   // nothing to deliver right after reset
   reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("leaf transaction valid after reset");

endmodule

bind tree_leaf_bfs_lister tlbl_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_last_node  (req_if.last_node),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_leaf_index (rsp_if.leaf_index),
   .rsp_last_leaf  (rsp_if.last_leaf)
);
